// ===== sv/lpc_pkg.sv =====
// Shared types and codes of the page cache controller.
// Holds the request and result structs and the controller to datapath bundles.
// No dependencies; every other file imports this package.
package lpc_pkg;

	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_PIN    = 3'd2;
	localparam logic [2:0] CMD_UNPIN  = 3'd3;
	localparam logic [2:0] CMD_FLUSH  = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  file_id;
		logic [23:0] page_number;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic        installed;
		logic        no_victim;
		logic        writeback;
		logic [7:0]  wb_file_id;
		logic [23:0] wb_page_number;
		logic        last;
	} rsp_t;

	// Kind of result the datapath loads into its output register.
	typedef enum logic [2:0] {
		EM_NONE,
		EM_LOOKUP,
		EM_PIN,
		EM_INSTALL,
		EM_FLUSH,
		EM_ZERO
	} emit_t;

	typedef struct packed {
		logic  capture;
		logic  match;
		logic  scan_start;
		logic  scan_step;
		emit_t emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       hit;
		logic       scan_last;
		logic       out_free;
	} dp_status_t;

endpackage

// ===== sv/lpc_datapath.sv =====
// Slot state, tag match, victim scan and result register of the page cache.
// Depends on lpc_pkg; driven by lpc_ctrl through dp_cmd_t and dp_status_t.
module lpc_datapath #(
	parameter int ENTRIES = 16,
	parameter int AGE_MAX = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpc_pkg::req_t       in_data,
	input  lpc_pkg::dp_cmd_t    dp_cmd,
	output lpc_pkg::dp_status_t dp_status,
	output logic                out_valid,
	input  logic                out_ready,
	output lpc_pkg::rsp_t       out_data
);
	import lpc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int AW = $clog2(AGE_MAX + 1);
	localparam logic [AW-1:0] AGE_TOP = AW'(AGE_MAX);
	localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

	function automatic logic [3:0] slot4(input logic [IW-1:0] idx);
		logic [IW+3:0] ext;
		ext = {4'b0, idx};
		return ext[3:0];
	endfunction

	// Per-slot state.
	logic [ENTRIES-1:0] valid_q, pin_q, dirty_q;
	logic [AW-1:0]      age_q   [ENTRIES];
	logic [AW-1:0]      age_inc [ENTRIES];
	logic [7:0]         file_q  [ENTRIES];
	logic [23:0]        page_q  [ENTRIES];

	// Current request and lookup result.
	logic [2:0]         cmd_q;
	logic [7:0]         key_file_q;
	logic [23:0]        key_page_q;
	logic [ENTRIES-1:0] match_q;
	logic               hit_any;
	logic [IW-1:0]      hit_idx;

	// Victim scan, also used as the flush walk.
	logic [IW-1:0] scan_idx_q;
	logic          scan_last;
	logic          pick;
	logic          best_found_q;
	logic [IW-1:0] best_idx_q;
	logic [AW-1:0] best_age_q;
	logic          best_dirty_q;
	logic [7:0]    best_file_q;
	logic [23:0]   best_page_q;

	logic out_valid_q;
	rsp_t out_q;
	rsp_t rsp_d;
	logic out_free;

	always_comb begin
		hit_any = |match_q;
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			age_inc[i] = (age_q[i] < AGE_TOP) ? age_q[i] + 1'b1 : age_q[i];
		end
	end

	assign scan_last = (scan_idx_q == IDX_LAST);
	assign pick = !pin_q[scan_idx_q] && (!best_found_q || (age_q[scan_idx_q] > best_age_q));
	assign out_free = !out_valid_q || out_ready;

	assign dp_status.command   = cmd_q;
	assign dp_status.hit       = hit_any;
	assign dp_status.scan_last = scan_last;
	assign dp_status.out_free  = out_free;

	always_comb begin
		rsp_d = '0;
		rsp_d.last = 1'b1;
		unique case (dp_cmd.emit)
			EM_LOOKUP: begin
				rsp_d.hit  = 1'b1;
				rsp_d.slot = slot4(hit_idx);
			end
			EM_PIN: begin
				rsp_d.hit = hit_any;
				if (hit_any) begin
					rsp_d.slot = slot4(hit_idx);
				end
			end
			EM_INSTALL: begin
				if (best_found_q) begin
					rsp_d.installed = 1'b1;
					rsp_d.slot      = slot4(best_idx_q);
					rsp_d.writeback = best_dirty_q;
					if (best_dirty_q) begin
						rsp_d.wb_file_id     = best_file_q;
						rsp_d.wb_page_number = best_page_q;
					end
				end else begin
					rsp_d.no_victim = 1'b1;
				end
			end
			EM_FLUSH: begin
				rsp_d.slot      = slot4(scan_idx_q);
				rsp_d.writeback = dirty_q[scan_idx_q];
				rsp_d.last      = scan_last;
				if (dirty_q[scan_idx_q]) begin
					rsp_d.wb_file_id     = file_q[scan_idx_q];
					rsp_d.wb_page_number = page_q[scan_idx_q];
				end
			end
			default: begin
			end
		endcase
	end

	// Control state: slot marks, ages, scan progress and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			pin_q        <= '0;
			dirty_q      <= '0;
			scan_idx_q   <= '0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (dp_cmd.emit != EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (dp_cmd.scan_start) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else if (dp_cmd.scan_step) begin
				scan_idx_q <= scan_last ? '0 : scan_idx_q + 1'b1;
				if (pick) begin
					best_found_q <= 1'b1;
				end
			end

			unique case (dp_cmd.emit)
				EM_LOOKUP: begin
					if (cmd_q == CMD_WRITE) begin
						dirty_q[hit_idx] <= 1'b1;
					end
					for (int i = 0; i < ENTRIES; i++) begin
						age_q[i] <= (IW'(i) == hit_idx) ? '0 : age_inc[i];
					end
				end
				EM_PIN: begin
					if (hit_any) begin
						pin_q[hit_idx] <= (cmd_q == CMD_PIN);
					end
				end
				EM_INSTALL: begin
					if (best_found_q) begin
						valid_q[best_idx_q] <= 1'b1;
						dirty_q[best_idx_q] <= 1'b0;
						for (int i = 0; i < ENTRIES; i++) begin
							age_q[i] <= (IW'(i) == best_idx_q) ? '0 : age_inc[i];
						end
					end
				end
				EM_FLUSH: begin
					dirty_q[scan_idx_q] <= 1'b0;
					pin_q[scan_idx_q]   <= 1'b0;
					age_q[scan_idx_q]   <= '0;
					scan_idx_q          <= scan_last ? '0 : scan_idx_q + 1'b1;
				end
				EM_ZERO: begin
					if (cmd_q == CMD_CLEAR) begin
						valid_q <= '0;
						pin_q   <= '0;
						dirty_q <= '0;
						for (int i = 0; i < ENTRIES; i++) begin
							age_q[i] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload: request key, tags, match vector, best candidate and result.
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q      <= in_data.command;
			key_file_q <= in_data.file_id;
			key_page_q <= in_data.page_number;
		end
		if (dp_cmd.match) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (file_q[i] == key_file_q)
					&& (page_q[i] == key_page_q);
			end
		end
		if (dp_cmd.scan_step && pick) begin
			best_idx_q   <= scan_idx_q;
			best_age_q   <= age_q[scan_idx_q];
			best_dirty_q <= dirty_q[scan_idx_q];
			best_file_q  <= file_q[scan_idx_q];
			best_page_q  <= page_q[scan_idx_q];
		end
		if (dp_cmd.emit == EM_INSTALL && best_found_q) begin
			file_q[best_idx_q] <= key_file_q;
			page_q[best_idx_q] <= key_page_q;
		end
		if (dp_cmd.emit != EM_NONE) begin
			out_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A result is only produced when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit != EM_NONE) |-> out_free)
		else $error("result loaded over an untaken result");

	// Only a write hit sets dirty, so a dirty slot always holds a valid tag.
	assert property (@(posedge clk) disable iff (!arst_n)
		((dirty_q & ~valid_q) == '0))
		else $error("dirty mark on an invalid slot");

	// A pin hit leaves the matched slot pinned.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit == EM_PIN && hit_any && cmd_q == CMD_PIN) |=> pin_q[$past(hit_idx)])
		else $error("pin command did not pin the matched slot");

endmodule

// ===== sv/lpc_ctrl.sv =====
// Sequencing state machine of the page cache controller.
// Depends on lpc_pkg; issues dp_cmd_t to lpc_datapath and reads dp_status_t.
module lpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpc_pkg::dp_status_t dp_status,
	output lpc_pkg::dp_cmd_t    dp_cmd
);
	import lpc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_SCAN,
		S_INSTALL,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		dp_cmd.emit = EM_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.capture = 1'b1;
					state_d = S_MATCH;
				end
			end
			S_MATCH: begin
				dp_cmd.match = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (dp_status.command) inside
					CMD_READ, CMD_WRITE: begin
						if (!dp_status.hit) begin
							dp_cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end else if (dp_status.out_free) begin
							dp_cmd.emit = EM_LOOKUP;
							state_d = S_IDLE;
						end
					end
					CMD_PIN, CMD_UNPIN: begin
						if (dp_status.out_free) begin
							dp_cmd.emit = EM_PIN;
							state_d = S_IDLE;
						end
					end
					CMD_FLUSH: begin
						dp_cmd.scan_start = 1'b1;
						state_d = S_FLUSH;
					end
					default: begin
						if (dp_status.out_free) begin
							dp_cmd.emit = EM_ZERO;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_SCAN: begin
				dp_cmd.scan_step = 1'b1;
				if (dp_status.scan_last) begin
					state_d = S_INSTALL;
				end
			end
			S_INSTALL: begin
				if (dp_status.out_free) begin
					dp_cmd.emit = EM_INSTALL;
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (dp_status.out_free) begin
					dp_cmd.emit = EM_FLUSH;
					if (dp_status.scan_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/lru_page_cache_controller_core.sv =====
// Page buffer pool tag and replacement controller.
//
// Requests enter on in_valid/in_ready with an in_data struct (command, file id,
// page number); results leave on out_valid/out_ready with an out_data struct.
// A transfer happens on a rising edge where valid and ready are both high.
// Every request gives one result, except flush all, which gives ENTRIES
// results in slot order; the final result of a request carries last.
//
// Sequence: after the request is captured and matched, a hit, pin, unpin or
// clear result is loaded when the output register is free. A miss walks the
// slots one per cycle to find the oldest unpinned one. Flush all gives one
// result per cycle while the output register is free. One request is worked
// on at a time; in_ready rises in the cycle after the last result is loaded.
//
// The result register decouples the sides: a new request can be taken while
// a result waits, and a stalled receiver only holds the controller when it
// next needs to load a result. Reset empties every slot and the result
// register.
module lru_page_cache_controller_core #(
	parameter int ENTRIES = 16,
	parameter int AGE_MAX = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lpc_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lpc_pkg::rsp_t  out_data
);
	import lpc_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	lpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	lpc_datapath #(
		.ENTRIES (ENTRIES),
		.AGE_MAX (AGE_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== dv/page_cache_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the page cache controller: watches both channels, predicts results.
// Depends on lpc_pkg for the request and result structs and the command codes.
module page_cache_checker #(
	parameter int ENTRIES = 16,
	parameter int AGE_MAX = 255
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  lpc_pkg::req_t in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  lpc_pkg::rsp_t out_data,
	output int            results_due,
	output int            mismatches
);
	import lpc_pkg::*;

	// Shadow copy of the slot table.
	logic        slot_used  [ENTRIES];
	logic [7:0]  tag_file   [ENTRIES];
	logic [23:0] tag_page   [ENTRIES];
	logic        pin_mark   [ENTRIES];
	logic        dirty_mark [ENTRIES];
	int          slot_age   [ENTRIES];

	rsp_t due_q[$];

	function automatic void clear_pool();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i]  = 1'b0;
			tag_file[i]   = '0;
			tag_page[i]   = '0;
			pin_mark[i]   = 1'b0;
			dirty_mark[i] = 1'b0;
			slot_age[i]   = 0;
		end
	endfunction

	function automatic int find_page(logic [7:0] fid, logic [23:0] pg);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && tag_file[i] == fid && tag_page[i] == pg)
				return i;
		return -1;
	endfunction

	function automatic void age_slots(int used);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_age[i] < AGE_MAX)
				slot_age[i]++;
		slot_age[used] = 0;
	endfunction

	function automatic void predict_pool_results(req_t r);
		rsp_t res;
		int   s;
		int   best_age;
		res      = '0;
		res.last = 1'b1;
		case (r.command)
			CMD_READ, CMD_WRITE: begin
				s = find_page(r.file_id, r.page_number);
				if (s >= 0) begin
					if (r.command == CMD_WRITE)
						dirty_mark[s] = 1'b1;
					age_slots(s);
					res.hit  = 1'b1;
					res.slot = s[3:0];
				end else begin
					// Oldest unpinned slot wins; a tie keeps the lower index.
					best_age = 0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (!pin_mark[i] && (s < 0 || slot_age[i] > best_age)) begin
							s        = i;
							best_age = slot_age[i];
						end
					end
					if (s < 0) begin
						res.no_victim = 1'b1;
					end else begin
						res.installed = 1'b1;
						res.slot      = s[3:0];
						if (dirty_mark[s]) begin
							res.writeback      = 1'b1;
							res.wb_file_id     = tag_file[s];
							res.wb_page_number = tag_page[s];
						end
						slot_used[s]  = 1'b1;
						tag_file[s]   = r.file_id;
						tag_page[s]   = r.page_number;
						dirty_mark[s] = 1'b0;
						age_slots(s);
					end
				end
				due_q.push_back(res);
			end
			CMD_PIN, CMD_UNPIN: begin
				s = find_page(r.file_id, r.page_number);
				if (s >= 0) begin
					pin_mark[s] = (r.command == CMD_PIN);
					res.hit     = 1'b1;
					res.slot    = s[3:0];
				end
				due_q.push_back(res);
			end
			CMD_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++) begin
					res      = '0;
					res.slot = i[3:0];
					if (dirty_mark[i]) begin
						res.writeback      = 1'b1;
						res.wb_file_id     = tag_file[i];
						res.wb_page_number = tag_page[i];
					end
					res.last = (i == ENTRIES - 1);
					due_q.push_back(res);
					dirty_mark[i] = 1'b0;
					pin_mark[i]   = 1'b0;
					slot_age[i]   = 0;
				end
			end
			CMD_CLEAR: begin
				clear_pool();
				due_q.push_back(res);
			end
			default: begin
				due_q.push_back(res);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < 40)
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_pool();
			due_q.delete();
			mismatches  = 0;
			results_due <= 0;
		end else begin
			// A result can never belong to a request taken at the same edge,
			// so the output side is checked before the new request is predicted.
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					report_mismatch("result with nothing expected", 64'(out_data), '0);
				end else begin
					want = due_q.pop_front();
					compare_field("hit", 64'(out_data.hit), 64'(want.hit));
					compare_field("slot", 64'(out_data.slot), 64'(want.slot));
					compare_field("installed", 64'(out_data.installed),
						64'(want.installed));
					compare_field("no_victim", 64'(out_data.no_victim),
						64'(want.no_victim));
					compare_field("writeback", 64'(out_data.writeback),
						64'(want.writeback));
					compare_field("wb_file_id", 64'(out_data.wb_file_id),
						64'(want.wb_file_id));
					compare_field("wb_page_number", 64'(out_data.wb_page_number),
						64'(want.wb_page_number));
					compare_field("last", 64'(out_data.last), 64'(want.last));
				end
			end
			if (in_valid && in_ready)
				predict_pool_results(in_data);
			results_due <= due_q.size();
		end
	end

endmodule

// ===== dv/lru_page_cache_controller_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the page cache controller testbench: clock, reset, stimulus and verdict.
// Depends on lpc_pkg, the controller core and page_cache_checker.
module lru_page_cache_controller_core_tb;
	import lpc_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int AGE_MAX        = 255;
	localparam int POOL_SIZE      = 20;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 190;

	// The two command codes the controller leaves unused.
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	req_t in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	int results_due;
	int mismatches;
	int items_sent   = 0;
	int quiet_cycles = 0;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;

	// Tags used by well-formed traffic so that hits, pins and evictions happen.
	logic [7:0]  pool_file [POOL_SIZE];
	logic [23:0] pool_page [POOL_SIZE];

	always #5 clk = ~clk;

	lru_page_cache_controller_core #(
		.ENTRIES(ENTRIES),
		.AGE_MAX(AGE_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	page_cache_checker #(
		.ENTRIES(ENTRIES),
		.AGE_MAX(AGE_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.results_due(results_due),
		.mismatches (mismatches)
	);

	// Receiver: random back-pressure, plus one long hold-off while requests keep coming.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && items_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [2:0] cmd, input logic [7:0] fid,
		input logic [23:0] pg);
		req_t r;
		r = '{command: cmd, file_id: fid, page_number: pg};
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		items_sent <= items_sent + 1;
	endtask

	// Stops offering requests until every predicted result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	function automatic logic [2:0] pick_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 36)
			return CMD_READ;
		if (roll < 66)
			return CMD_WRITE;
		if (roll < 78)
			return CMD_PIN;
		if (roll < 90)
			return CMD_UNPIN;
		if (roll < 93)
			return CMD_FLUSH;
		if (roll < 95)
			return CMD_CLEAR;
		if (roll < 97)
			return CMD_SPARE6;
		return CMD_SPARE7;
	endfunction

	task automatic send_random_item();
		int k;
		k = $urandom_range(0, POOL_SIZE - 1);
		if ($urandom_range(0, 99) < 80)
			send_request(pick_command(), pool_file[k], pool_page[k]);
		else
			send_request(pick_command(), 8'($urandom_range(0, 255)),
				24'($urandom_range(0, 24'hFFFFFF)));
	endtask

	// Installs and pins one tag per slot until all are pinned, then misses,
	// frees one slot, refills it and flushes. Sends 2 * ENTRIES + 4 requests.
	task automatic send_pin_storm();
		for (int i = 0; i < ENTRIES; i++) begin
			send_request(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ,
				pool_file[i], pool_page[i]);
			send_request(CMD_PIN, pool_file[i], pool_page[i]);
		end
		send_request(CMD_READ, 8'($urandom_range(0, 255)),
			24'($urandom_range(0, 24'hFFFFFF)));
		send_request(CMD_UNPIN, pool_file[5], pool_page[5]);
		send_request(CMD_WRITE, pool_file[POOL_SIZE - 1], pool_page[POOL_SIZE - 1]);
		send_request(CMD_FLUSH, 8'($urandom_range(0, 255)),
			24'($urandom_range(0, 24'hFFFFFF)));
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
		input bit lead_storm);
		int sent;
		sent        = 0;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (lead_storm) begin
			send_pin_storm();
			sent += 2 * ENTRIES + 4;
		end
		while (sent < count) begin
			if ($urandom_range(0, 99) < 4) begin
				send_pin_storm();
				sent += 2 * ENTRIES + 4;
			end else begin
				send_random_item();
				sent++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_file[i] = 8'($urandom_range(0, 255));
			pool_page[i] = {16'($urandom_range(0, 16'hFFFF)), i[7:0]};
		end
		pool_file[0] = 8'h00;
		pool_page[0] = 24'h000000;
		pool_file[1] = 8'hFF;
		pool_page[1] = 24'hFFFFFF;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 18;
		rx_idle_pct = 70;

		// Directed opening. The all-zero tag must miss while every slot is still invalid.
		send_request(CMD_READ, 8'h00, 24'h000000);
		send_request(CMD_READ, 8'h00, 24'h000000);
		send_request(CMD_WRITE, 8'hFF, 24'hFFFFFF);
		send_request(CMD_WRITE, 8'hFF, 24'hFFFFFF);
		send_request(CMD_PIN, 8'hFF, 24'hFFFFFF);
		send_request(CMD_PIN, 8'h12, 24'h345678);
		send_request(CMD_UNPIN, 8'hFF, 24'hFFFFFF);
		send_request(CMD_UNPIN, 8'h12, 24'h345678);
		send_request(CMD_WRITE, 8'h55, 24'hAAAAAA);
		send_request(CMD_WRITE, 8'hAA, 24'h555555);
		send_request(CMD_SPARE6, 8'h3C, 24'hC3C3C3);
		send_request(CMD_SPARE7, 8'hFF, 24'hFFFFFF);
		send_request(CMD_FLUSH, 8'h00, 24'h000000);
		send_request(CMD_WRITE, 8'h00, 24'h000000);
		send_request(CMD_PIN, 8'h00, 24'h000000);
		send_request(CMD_FLUSH, 8'hFF, 24'hFFFFFF);
		send_request(CMD_CLEAR, 8'h00, 24'h000000);
		send_request(CMD_READ, 8'hFF, 24'hFFFFFF);
		send_request(CMD_WRITE, 8'hFF, 24'hFFFFFF);
		send_request(CMD_FLUSH, 8'h00, 24'h000000);
		wait_drained();

		run_phase(18, 70, 70, 1'b0);
		wait_drained();
		run_phase(70, 18, 70, 1'b1);
		wait_drained();
		run_phase(0, 0, 60, 1'b0);
		wait_drained();

		repeat (ENTRIES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
